// ===== rtl/resource_grid_regrow_consume_top_assert.svh =====
// ----------------------------------------------------------------------------
// resource grid assertion macros
// clocked property checks used by the rgrc_engine rtl file of the resource grid
// ----------------------------------------------------------------------------
`ifndef RESOURCE_GRID_REGROW_CONSUME_TOP_ASSERT_SVH
`define RESOURCE_GRID_REGROW_CONSUME_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define RGRC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RGRC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgrc_pkg
// sizes, codes and bus types of the resource grid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgrc_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int MAX_RADIUS  = 7;
   localparam int LEVEL_BITS  = 16;

   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_BITS  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   localparam int OP_BITS     = 2;
   localparam int COORD_BITS  = 8;
   localparam int QTY_BITS    = 16;
   localparam int RADIUS_BITS = 3;
   localparam int DIM_BITS    = 7;
   localparam int WIN_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIM_BITS;
   localparam int SUM_BITS    = ((LEVEL_BITS > QTY_BITS) ? LEVEL_BITS : QTY_BITS) + 1;
   localparam int CMP_BITS    = (LEVEL_BITS > QTY_BITS) ? LEVEL_BITS : QTY_BITS;

   localparam int REQ_DATA_BITS  = 40;
   localparam int RSP_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [OP_BITS-1:0] OP_REFILL  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REGROW  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CONSUME = 2'd2;
   localparam logic [OP_BITS-1:0] OP_FIND    = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LEVEL   = 2'd2;

   localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 7'd64;
   localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 7'd64;
   localparam logic [QTY_BITS-1:0] RESET_LEVEL  = 16'd4096;

   typedef struct packed {
      logic [DIM_BITS-1:0] grid_width;
      logic [DIM_BITS-1:0] grid_height;
      logic [QTY_BITS-1:0] max_level;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]            op;
      logic signed [COORD_BITS-1:0]  cell_x;
      logic signed [COORD_BITS-1:0]  cell_y;
      logic [QTY_BITS-1:0]           quantity;
      logic [RADIUS_BITS-1:0]        radius;
   } req_type;

   typedef struct packed {
      logic [QTY_BITS-1:0]           taken;
      logic signed [COORD_BITS-1:0]  best_x;
      logic signed [COORD_BITS-1:0]  best_y;
   } rsp_type;

endpackage

// ===== rtl/resource_grid_regrow_consume_top.sv =====
// ----------------------------------------------------------------------------
// resource_grid_regrow_consume_top
// Grid of Q8.8 resource levels held in one 4096-entry ram, one access port
// each for read and write. Items are taken one at a time and each gives one
// result. Consume reads the cell and writes it back reduced, skipping both
// for a zero quantity or an off-grid cell; find best scans the (2r+1)^2
// window at one window cell per cycle; a radius zero search or zero-rate
// regrow goes straight to the result. Refill and regrow sweep every entry
// of the ram at one cell per cycle. After reset a clearing pass sets all
// levels to 4096 and holds req_tready low; csr writes are taken at any time.
// A finished result waits in the output register as the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resource_grid_regrow_consume_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // cell_x, cell_y, quantity, radius, zero pad
   input  logic [rgrc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // op
   input  logic [rgrc_pkg::OP_BITS-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // taken, best_x, best_y
   output logic [rgrc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rgrc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rgrc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import rgrc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type item;
   rsp_type res, rsp_ff;
   logic    rsp_tvalid_ff, rsp_tvalid_in;
   logic    out_free;
   logic    res_valid;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  cfg_in.grid_width  = DIM_BITS'(csr_data);
            REG_GRID_HEIGHT: cfg_in.grid_height = DIM_BITS'(csr_data);
            REG_MAX_LEVEL:   cfg_in.max_level   = QTY_BITS'(csr_data);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= RESET_WIDTH;
         cfg_ff.grid_height <= RESET_HEIGHT;
         cfg_ff.max_level   <= RESET_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   assign item.op       = req_tuser;
   assign item.cell_x   = req_tdata[7:0];
   assign item.cell_y   = req_tdata[15:8];
   assign item.quantity = req_tdata[31:16];
   assign item.radius   = req_tdata[34:32];

   rgrc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   // output register
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (res_valid) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ff.best_y, rsp_ff.best_x, rsp_ff.taken};

endmodule

// ===== rtl/rgrc_ram.sv =====
// ----------------------------------------------------------------------------
// rgrc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgrc_engine.sv =====
// ----------------------------------------------------------------------------
// rgrc_engine
// sequencer around the level ram: clear, refill, regrow, consume and search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resource_grid_regrow_consume_top_assert.svh"

module rgrc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  rgrc_pkg::req_type item,
   input  rgrc_pkg::cfg_type cfg,
   input  logic              out_free,
   output logic              res_valid,
   output rgrc_pkg::rsp_type res
);

   import rgrc_pkg::*;

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_FILL       = 4'd2;
   localparam logic [3:0] S_SWEEP      = 4'd3;
   localparam logic [3:0] S_SWEEP_TAIL = 4'd4;
   localparam logic [3:0] S_CONS_RD    = 4'd5;
   localparam logic [3:0] S_CONS_WR    = 4'd6;
   localparam logic [3:0] S_SCAN       = 4'd7;
   localparam logic [3:0] S_SCAN_TAIL  = 4'd8;
   localparam logic [3:0] S_DONE       = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [ADDR_BITS-1:0]        addr_ff, addr_in;
   req_type                     req_ff, req_in;
   logic signed [WIN_BITS-1:0]  xlo_ff, xlo_in;
   logic signed [WIN_BITS-1:0]  xhi_ff, xhi_in;
   logic signed [WIN_BITS-1:0]  yhi_ff, yhi_in;
   logic signed [WIN_BITS-1:0]  x_ff, x_in;
   logic signed [WIN_BITS-1:0]  y_ff, y_in;
   logic                        p1_valid_ff, p1_valid_in;
   logic [ADDR_BITS-1:0]        p1_addr_ff, p1_addr_in;
   logic signed [WIN_BITS-1:0]  p1_x_ff, p1_y_ff;
   logic                        found_ff, found_in;
   logic [LEVEL_BITS-1:0]       best_ff, best_in;
   logic [QTY_BITS-1:0]         taken_ff, taken_in;
   logic signed [COORD_BITS-1:0] bx_ff, bx_in;
   logic signed [COORD_BITS-1:0] by_ff, by_in;

   logic [DIM_BITS-1:0]         eff_w, eff_h;
   logic [RADIUS_BITS-1:0]      r_clamp;
   logic signed [WIN_BITS-1:0]  cur_x, cur_y;
   logic                        cell_inb;
   logic [PROD_BITS-1:0]        cell_lin;
   logic [ADDR_BITS-1:0]        cell_addr;
   logic                        addr_last;
   logic                        scanning;
   logic                        sweeping;

   logic                        rd_en, wr_en;
   logic [ADDR_BITS-1:0]        rd_addr, wr_addr;
   logic [LEVEL_BITS-1:0]       rd_data, wr_data;
   logic [SUM_BITS-1:0]         grow_sum, grow_cap;
   logic [CMP_BITS-1:0]         lv_ext, qty_ext, take_ext;

   assign eff_w   = (int'(cfg.grid_width) > MAX_COLUMNS) ? DIM_BITS'(MAX_COLUMNS)
                                                         : cfg.grid_width;
   assign eff_h   = (int'(cfg.grid_height) > MAX_ROWS) ? DIM_BITS'(MAX_ROWS)
                                                       : cfg.grid_height;
   assign r_clamp = (int'(item.radius) > MAX_RADIUS) ? RADIUS_BITS'(MAX_RADIUS)
                                                     : item.radius;

   assign cur_x = (state_ff == S_SCAN) ? x_ff : WIN_BITS'(req_ff.cell_x);
   assign cur_y = (state_ff == S_SCAN) ? y_ff : WIN_BITS'(req_ff.cell_y);

   assign cell_inb  = !cur_x[WIN_BITS-1] && !cur_y[WIN_BITS-1]
                      && (cur_x[WIN_BITS-2:0] < COORD_BITS'(eff_w))
                      && (cur_y[WIN_BITS-2:0] < COORD_BITS'(eff_h));
   assign cell_lin  = PROD_BITS'(cur_y[DIM_BITS-1:0]) * PROD_BITS'(eff_w)
                      + PROD_BITS'(cur_x[DIM_BITS-1:0]);
   assign cell_addr = ADDR_BITS'(cell_lin);
   assign addr_last = (addr_ff == ADDR_BITS'(CELL_COUNT - 1));
   assign scanning  = (state_ff == S_SCAN) || (state_ff == S_SCAN_TAIL);
   assign sweeping  = (state_ff == S_SWEEP) || (state_ff == S_SWEEP_TAIL);

   // read side
   assign rd_en   = (state_ff == S_SWEEP)
                    || ((state_ff == S_CONS_RD) && cell_inb && (req_ff.quantity != '0))
                    || ((state_ff == S_SCAN) && cell_inb);
   assign rd_addr = (state_ff == S_SWEEP) ? addr_ff : cell_addr;

   // saturating regrow on returned data
   assign grow_sum = SUM_BITS'(rd_data) + SUM_BITS'(req_ff.quantity);
   assign grow_cap = (grow_sum > SUM_BITS'(cfg.max_level)) ? SUM_BITS'(cfg.max_level)
                                                           : grow_sum;

   // consume amount
   assign lv_ext   = CMP_BITS'(rd_data);
   assign qty_ext  = CMP_BITS'(req_ff.quantity);
   assign take_ext = (lv_ext < qty_ext) ? lv_ext : qty_ext;

   // write side
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = p1_addr_ff;
      wr_data = rd_data;
      unique case (state_ff) inside
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = LEVEL_BITS'(RESET_LEVEL);
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = LEVEL_BITS'(cfg.max_level);
         end
         S_SWEEP, S_SWEEP_TAIL: begin
            wr_en   = p1_valid_ff;
            wr_data = LEVEL_BITS'(grow_cap);
         end
         S_CONS_WR: begin
            wr_en   = 1'b1;
            wr_data = LEVEL_BITS'(lv_ext - take_ext);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   rgrc_ram #(
      .WIDTH (LEVEL_BITS),
      .DEPTH (CELL_COUNT)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign p1_valid_in = rd_en && ((state_ff == S_SWEEP) || (state_ff == S_SCAN));
   assign p1_addr_in  = rd_addr;

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      req_in   = req_ff;
      xlo_in   = xlo_ff;
      xhi_in   = xhi_ff;
      yhi_in   = yhi_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      found_in = found_ff;
      best_in  = best_ff;
      taken_in = taken_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;

      unique case (state_ff) inside
         S_CLEAR, S_FILL: begin
            addr_in = addr_ff + ADDR_BITS'(1);
            if (addr_last) begin
               addr_in  = '0;
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               req_in   = item;
               found_in = 1'b0;
               taken_in = '0;
               bx_in    = item.cell_x;
               by_in    = item.cell_y;
               xlo_in   = WIN_BITS'(item.cell_x) - WIN_BITS'(r_clamp);
               xhi_in   = WIN_BITS'(item.cell_x) + WIN_BITS'(r_clamp);
               yhi_in   = WIN_BITS'(item.cell_y) + WIN_BITS'(r_clamp);
               x_in     = WIN_BITS'(item.cell_x) - WIN_BITS'(r_clamp);
               y_in     = WIN_BITS'(item.cell_y) - WIN_BITS'(r_clamp);
               unique case (item.op)
                  OP_REFILL:  state_in = S_FILL;
                  OP_REGROW:  state_in = (item.quantity != '0) ? S_SWEEP : S_DONE;
                  OP_CONSUME: state_in = S_CONS_RD;
                  OP_FIND:    state_in = (r_clamp != '0) ? S_SCAN : S_DONE;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_SWEEP: begin
            addr_in = addr_ff + ADDR_BITS'(1);
            if (addr_last) begin
               addr_in  = '0;
               state_in = S_SWEEP_TAIL;
            end
         end
         S_CONS_RD: begin
            state_in = rd_en ? S_CONS_WR : S_DONE;
         end
         S_CONS_WR: begin
            taken_in = QTY_BITS'(take_ext);
            state_in = S_DONE;
         end
         S_SCAN: begin
            x_in = x_ff + WIN_BITS'(1);
            if (x_ff == xhi_ff) begin
               x_in = xlo_ff;
               y_in = y_ff + WIN_BITS'(1);
               if (y_ff == yhi_ff) begin
                  state_in = S_SCAN_TAIL;
               end
            end
         end
         S_SWEEP_TAIL, S_SCAN_TAIL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // first strictly higher level wins
      if (scanning && p1_valid_ff && (!found_ff || (rd_data > best_ff))) begin
         found_in = 1'b1;
         best_in  = rd_data;
         bx_in    = COORD_BITS'(p1_x_ff);
         by_in    = COORD_BITS'(p1_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         addr_ff     <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      xlo_ff     <= xlo_in;
      xhi_ff     <= xhi_in;
      yhi_ff     <= yhi_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      p1_addr_ff <= p1_addr_in;
      p1_x_ff    <= cur_x;
      p1_y_ff    <= cur_y;
      found_ff   <= found_in;
      best_ff    <= best_in;
      taken_ff   <= taken_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
   end

   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE) && out_free;
   assign res.taken  = taken_ff;
   assign res.best_x = bx_ff;
   assign res.best_y = by_ff;

   `RGRC_ASSERT(a_no_rw_collide, clock, reset, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit the same cell")
   `RGRC_ASSERT(a_consume_no_gain, clock, reset, (state_ff == S_CONS_WR) |-> (wr_data <= rd_data), "consume raised a level")
   `RGRC_ASSERT(a_regrow_capped, clock, reset, (wr_en && sweeping) |-> (SUM_BITS'(wr_data) <= SUM_BITS'(cfg.max_level)), "regrow wrote above capacity")
   `RGRC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, item_valid && item_ready, state_ff != S_IDLE, "accepted item left sequencer idle")

endmodule
